// ===== rtl/jpeg_marker_segment_parser_assert.svh =====
// Assertion macros used by the parser checker.
`ifndef JPEG_MARKER_SEGMENT_PARSER_ASSERT_SVH
`define JPEG_MARKER_SEGMENT_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define JMSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define JMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jmsp_pkg.sv =====
// Shared types, codes and helpers of the JPEG marker segment parser.
`default_nettype none

package jmsp_pkg;

  // width of the running byte offset counter (wraps)
  localparam int OFFSET_WIDTH = 32;
  localparam int OFFSET_CAP   = 48;

  localparam logic [2:0] KIND_SOI       = 3'd0;
  localparam logic [2:0] KIND_SEGMENT   = 3'd1;
  localparam logic [2:0] KIND_COMPONENT = 3'd2;
  localparam logic [2:0] KIND_SCAN      = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_SOI     = 3'd1;
  localparam logic [2:0] ERR_EARLY_END  = 3'd2;
  localparam logic [2:0] ERR_BAD_MARKER = 3'd3;
  localparam logic [2:0] ERR_BODY_SHORT = 3'd4;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_SOF2   = 8'hC2;
  localparam logic [7:0] MARK_DRI    = 8'hDD;
  localparam logic [7:0] MARK_SOS    = 8'hDA;

  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [7:0]  NIBBLE_MASK = 8'd15;

  typedef enum logic [9:0] {
    PH_SOI1 = 10'b0000000001,
    PH_SOI2 = 10'b0000000010,
    PH_MK1  = 10'b0000000100,
    PH_MK2  = 10'b0000001000,
    PH_LEN1 = 10'b0000010000,
    PH_LEN2 = 10'b0000100000,
    PH_BODY = 10'b0001000000,
    PH_SCAN = 10'b0010000000,
    PH_IDLE = 10'b0100000000,
    PH_HALT = 10'b1000000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [7:0]  marker_code;
    logic [31:0] segment_offset;
    logic [15:0] body_length;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [7:0]  value_c;
    logic [7:0]  value_d;
    logic        last;
  } result_t;

  // up to two result words raised by one input word
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } res_pair_t;

  function automatic logic [31:0] to_off32(input logic [OFFSET_WIDTH-1:0] v);
    logic [OFFSET_CAP-1:0] w;
    w = OFFSET_CAP'(v);
    return w[31:0];
  endfunction

  function automatic result_t mk_result(
    input logic [2:0]  kind,
    input logic [2:0]  err,
    input logic [7:0]  mk,
    input logic [31:0] off,
    input logic [15:0] len,
    input logic [15:0] a,
    input logic [15:0] b,
    input logic [7:0]  c,
    input logic [7:0]  d
  );
    result_t r;
    r.kind           = kind;
    r.error_code     = err;
    r.marker_code    = mk;
    r.segment_offset = off;
    r.body_length    = len;
    r.value_a        = a;
    r.value_b        = b;
    r.value_c        = c;
    r.value_d        = d;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jpeg_marker_segment_parser.sv =====
// JPEG marker segment parser: takes one file byte per clock and reports the
// start-of-image, every segment (marker, offset, body length, SOF/DRI/SOS
// fields), SOF and SOS component records, the scan start and errors. A byte is
// taken whenever in_valid is high and in_stall low; its results go into a
// four-word output queue at that same edge, so a result word can leave on
// the next cycle. The output side gives one word per cycle while out_stall
// is low; a byte that raises two words (a record or segment followed by an
// error, or an SOS record with the segment word) writes both at once.
// in_stall rises while fewer than two queue slots are free, so input
// throughput is one byte per cycle while the output keeps up. After an
// error or the scan start, bytes are swallowed until a file_start byte.
`default_nettype none

module jpeg_marker_segment_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        file_start,
  input  wire logic        file_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [2:0]       error_code,
  output logic [7:0]       marker_code,
  output logic [31:0]      segment_offset,
  output logic [15:0]      body_length,
  output logic [15:0]      value_a,
  output logic [15:0]      value_b,
  output logic [7:0]       value_c,
  output logic [7:0]       value_d,
  output logic             last
);

  jmsp_pkg::res_pair_t pair;
  jmsp_pkg::result_t   head;
  logic                room_two, take;

  assign in_stall = !room_two;
  assign take     = in_valid && room_two;

  jmsp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .file_start (file_start),
    .file_end   (file_end),
    .res        (pair)
  );

  jmsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pair),
    .pop       (!out_stall),
    .head      (head),
    .not_empty (out_valid),
    .room_two  (room_two)
  );

  assign kind           = head.kind;
  assign error_code     = head.error_code;
  assign marker_code    = head.marker_code;
  assign segment_offset = head.segment_offset;
  assign body_length    = head.body_length;
  assign value_a        = head.value_a;
  assign value_b        = head.value_b;
  assign value_c        = head.value_c;
  assign value_d        = head.value_d;
  assign last           = head.last;

endmodule

`default_nettype wire

// ===== rtl/jmsp_core.sv =====
// Per-byte parse state and result generation of the marker segment parser.
`default_nettype none

module jmsp_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [7:0]          data_byte,
  input  wire logic                file_start,
  input  wire logic                file_end,
  output jmsp_pkg::res_pair_t      res
);

  localparam int OW = jmsp_pkg::OFFSET_WIDTH;

  jmsp_pkg::phase_t phase, phase_next, eff_phase;
  logic [OW-1:0] byte_position, byte_position_next, pos;
  logic [OW-1:0] segment_start, segment_start_next;
  logic [7:0]    marker_low, marker_low_next;
  logic [7:0]    length_high, length_high_next;
  logic [15:0]   body_size, body_size_next;
  logic [15:0]   body_index, body_index_next;
  logic [15:0]   field_one, field_one_next;
  logic [15:0]   field_two, field_two_next;
  logic [7:0]    field_three, field_three_next;
  logic [7:0]    count_of_components, count_of_components_next;
  logic [15:0]   component_bytes, component_bytes_next;
  // SOF component walk: byte within record and record number
  logic [1:0]    comp_at, comp_at_next;
  logic [15:0]   comp_rec, comp_rec_next;

  logic          done, is_sof;
  logic [8:0]    tail;
  logic [15:0]   tail16, tail16_p1, tail16_p2, len_word, idx;
  logic          has_a, has_b, has_c;
  jmsp_pkg::result_t res_a, res_b, res_c, slot0, slot1;
  logic [2:0]    c_err;
  logic [7:0]    c_mk;
  logic [OW-1:0] c_off;
  logic [15:0]   c_len;
  logic [1:0]    n_res;

  always_comb begin
    eff_phase = file_start ? jmsp_pkg::PH_SOI1 : phase;
    pos       = file_start ? '0 : byte_position;
    if (file_start) begin
      segment_start_next       = '0;
      marker_low_next          = '0;
      length_high_next         = '0;
      body_size_next           = '0;
      body_index_next          = '0;
      field_one_next           = '0;
      field_two_next           = '0;
      field_three_next         = '0;
      count_of_components_next = '0;
      component_bytes_next     = '0;
      comp_at_next             = '0;
      comp_rec_next            = '0;
    end else begin
      segment_start_next       = segment_start;
      marker_low_next          = marker_low;
      length_high_next         = length_high;
      body_size_next           = body_size;
      body_index_next          = body_index;
      field_one_next           = field_one;
      field_two_next           = field_two;
      field_three_next         = field_three;
      count_of_components_next = count_of_components;
      component_bytes_next     = component_bytes;
      comp_at_next             = comp_at;
      comp_rec_next            = comp_rec;
    end
    phase_next         = eff_phase;
    byte_position_next = pos + OW'(1);

    idx       = body_index_next;
    done      = 1'b0;
    is_sof    = (marker_low_next == jmsp_pkg::MARK_SOF0) ||
                (marker_low_next == jmsp_pkg::MARK_SOF2);
    tail      = {count_of_components_next, 1'b1};
    tail16    = {7'd0, tail};
    tail16_p1 = tail16 + 16'd1;
    tail16_p2 = tail16 + 16'd2;
    len_word  = {length_high_next, data_byte};

    has_a = 1'b0;
    has_b = 1'b0;
    has_c = 1'b0;
    res_a = '0;
    c_err = jmsp_pkg::ERR_NONE;
    c_mk  = '0;
    c_off = '0;
    c_len = '0;

    case (eff_phase)
      jmsp_pkg::PH_SOI1: begin
        if (data_byte != jmsp_pkg::MARK_PREFIX || file_end) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_NO_SOI;
          phase_next = jmsp_pkg::PH_HALT;
        end else begin
          phase_next = jmsp_pkg::PH_SOI2;
        end
      end
      jmsp_pkg::PH_SOI2: begin
        if (data_byte != jmsp_pkg::MARK_SOI) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_NO_SOI;
          phase_next = jmsp_pkg::PH_HALT;
        end else begin
          has_a = 1'b1;
          res_a = jmsp_pkg::mk_result(jmsp_pkg::KIND_SOI, jmsp_pkg::ERR_NONE,
                                      jmsp_pkg::MARK_SOI, 32'd0, 16'd0, 16'd0, 16'd0,
                                      8'd0, 8'd0);
          if (file_end) begin
            has_c      = 1'b1;
            c_err      = jmsp_pkg::ERR_EARLY_END;
            c_off      = pos + OW'(1);
            phase_next = jmsp_pkg::PH_HALT;
          end else begin
            phase_next = jmsp_pkg::PH_MK1;
          end
        end
      end
      jmsp_pkg::PH_MK1: begin
        segment_start_next       = pos;
        marker_low_next          = '0;
        length_high_next         = '0;
        body_size_next           = '0;
        body_index_next          = '0;
        field_one_next           = '0;
        field_two_next           = '0;
        field_three_next         = '0;
        count_of_components_next = '0;
        component_bytes_next     = '0;
        comp_at_next             = '0;
        comp_rec_next            = '0;
        c_off                    = pos;
        if (data_byte != jmsp_pkg::MARK_PREFIX) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_BAD_MARKER;
          phase_next = jmsp_pkg::PH_HALT;
        end else if (file_end) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_EARLY_END;
          phase_next = jmsp_pkg::PH_HALT;
        end else begin
          phase_next = jmsp_pkg::PH_MK2;
        end
      end
      jmsp_pkg::PH_MK2, jmsp_pkg::PH_LEN1: begin
        if (eff_phase == jmsp_pkg::PH_MK2) begin
          marker_low_next = data_byte;
        end else begin
          length_high_next = data_byte;
        end
        c_mk  = marker_low_next;
        c_off = segment_start_next;
        if (file_end) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_EARLY_END;
          phase_next = jmsp_pkg::PH_HALT;
        end else if (eff_phase == jmsp_pkg::PH_MK2) begin
          phase_next = jmsp_pkg::PH_LEN1;
        end else begin
          phase_next = jmsp_pkg::PH_LEN2;
        end
      end
      jmsp_pkg::PH_LEN2: begin
        c_mk  = marker_low_next;
        c_off = segment_start_next;
        if (len_word <= jmsp_pkg::LEN_MIN) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_BAD_MARKER;
          phase_next = jmsp_pkg::PH_HALT;
        end else begin
          body_size_next  = len_word - jmsp_pkg::LEN_MIN;
          body_index_next = '0;
          if (file_end) begin
            has_c      = 1'b1;
            c_err      = jmsp_pkg::ERR_BODY_SHORT;
            c_len      = body_size_next;
            phase_next = jmsp_pkg::PH_HALT;
          end else begin
            phase_next = jmsp_pkg::PH_BODY;
          end
        end
      end
      jmsp_pkg::PH_BODY: begin
        body_index_next = idx + 16'd1;
        done            = (body_index_next >= body_size_next);
        if (is_sof) begin
          if (idx == 16'd0) begin
            field_three_next = data_byte;
          end else if (idx <= 16'd2) begin
            field_one_next = {field_one_next[7:0], data_byte};
          end else if (idx <= 16'd4) begin
            field_two_next = {field_two_next[7:0], data_byte};
          end else if (idx == 16'd5) begin
            count_of_components_next = data_byte;
          end else begin
            if (comp_rec_next < {8'd0, count_of_components_next}) begin
              case (comp_at_next)
                2'd0: component_bytes_next = {data_byte, 8'd0};
                2'd1: component_bytes_next = component_bytes_next | {8'd0, data_byte};
                default: begin
                  has_a = 1'b1;
                  res_a = jmsp_pkg::mk_result(jmsp_pkg::KIND_COMPONENT,
                            jmsp_pkg::ERR_NONE, marker_low_next,
                            jmsp_pkg::to_off32(segment_start_next), body_size_next,
                            {8'd0, component_bytes_next[15:8]},
                            {12'd0, component_bytes_next[7:4]},
                            {4'd0, component_bytes_next[3:0]}, data_byte);
                end
              endcase
            end
            // record walk in place of (i - 6) / 3 and (i - 6) % 3
            if (comp_at_next == 2'd2) begin
              comp_at_next  = 2'd0;
              comp_rec_next = comp_rec_next + 16'd1;
            end else begin
              comp_at_next = comp_at_next + 2'd1;
            end
          end
          if (idx == 16'd5 || (done && idx < 16'd5)) begin
            has_b = 1'b1;
          end
        end else if (marker_low_next == jmsp_pkg::MARK_DRI) begin
          if (idx <= 16'd1) begin
            field_one_next = {field_one_next[7:0], data_byte};
          end
        end else if (marker_low_next == jmsp_pkg::MARK_SOS) begin
          if (idx == 16'd0) begin
            count_of_components_next = data_byte;
          end else if (idx < tail16) begin
            if (idx[0]) begin
              component_bytes_next = {8'd0, data_byte};
            end else begin
              has_a = 1'b1;
              res_a = jmsp_pkg::mk_result(jmsp_pkg::KIND_COMPONENT,
                        jmsp_pkg::ERR_NONE, marker_low_next,
                        jmsp_pkg::to_off32(segment_start_next), body_size_next,
                        component_bytes_next, {12'd0, data_byte[7:4]},
                        {4'd0, data_byte[3:0]}, 8'd0);
            end
          end else if (idx == tail16) begin
            field_one_next = {8'd0, data_byte};
          end else if (idx == tail16_p1) begin
            field_two_next = {8'd0, data_byte};
          end else if (idx == tail16_p2) begin
            field_three_next = data_byte;
          end
        end

        if (done) begin
          if (!is_sof) begin
            has_b = 1'b1;
          end
          if (marker_low_next == jmsp_pkg::MARK_SOS) begin
            phase_next = jmsp_pkg::PH_SCAN;
          end else if (file_end) begin
            has_c      = 1'b1;
            c_err      = jmsp_pkg::ERR_EARLY_END;
            c_off      = pos + OW'(1);
            phase_next = jmsp_pkg::PH_HALT;
          end else begin
            phase_next = jmsp_pkg::PH_MK1;
          end
        end else if (file_end) begin
          has_c      = 1'b1;
          c_err      = jmsp_pkg::ERR_BODY_SHORT;
          c_mk       = marker_low_next;
          c_off      = segment_start_next;
          c_len      = body_size_next;
          phase_next = jmsp_pkg::PH_HALT;
        end
      end
      jmsp_pkg::PH_SCAN: begin
        has_a = 1'b1;
        res_a = jmsp_pkg::mk_result(jmsp_pkg::KIND_SCAN, jmsp_pkg::ERR_NONE,
                                    jmsp_pkg::MARK_SOS, jmsp_pkg::to_off32(pos), 16'd0,
                                    16'd0, 16'd0, 8'd0, 8'd0);
        phase_next = jmsp_pkg::PH_IDLE;
      end
      default: begin
        phase_next = eff_phase;
      end
    endcase

    res_b = jmsp_pkg::mk_result(jmsp_pkg::KIND_SEGMENT, jmsp_pkg::ERR_NONE,
                                marker_low_next, jmsp_pkg::to_off32(segment_start_next),
                                body_size_next, field_one_next, field_two_next,
                                field_three_next, count_of_components_next);
    res_c = jmsp_pkg::mk_result(jmsp_pkg::KIND_ERROR, c_err, c_mk,
                                jmsp_pkg::to_off32(c_off), c_len, 16'd0, 16'd0,
                                8'd0, 8'd0);

    // pack in order: record or start word, segment word, error word
    slot0 = has_a ? res_a : (has_b ? res_b : res_c);
    slot1 = (has_a && has_b) ? res_b : res_c;
    n_res = 2'(has_a) + 2'(has_b) + 2'(has_c);
    slot0.last = (n_res == 2'd1);
    slot1.last = 1'b1;

    res.count  = take ? n_res : 2'd0;
    res.first  = slot0;
    res.second = slot1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= jmsp_pkg::PH_SOI1;
      byte_position       <= '0;
      segment_start       <= '0;
      marker_low          <= '0;
      length_high         <= '0;
      body_size           <= '0;
      body_index          <= '0;
      field_one           <= '0;
      field_two           <= '0;
      field_three         <= '0;
      count_of_components <= '0;
      component_bytes     <= '0;
      comp_at             <= '0;
      comp_rec            <= '0;
    end else if (take) begin
      phase               <= phase_next;
      byte_position       <= byte_position_next;
      segment_start       <= segment_start_next;
      marker_low          <= marker_low_next;
      length_high         <= length_high_next;
      body_size           <= body_size_next;
      body_index          <= body_index_next;
      field_one           <= field_one_next;
      field_two           <= field_two_next;
      field_three         <= field_three_next;
      count_of_components <= count_of_components_next;
      component_bytes     <= component_bytes_next;
      comp_at             <= comp_at_next;
      comp_rec            <= comp_rec_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jmsp_queue.sv =====
// Four-word result queue: up to two in per cycle, one out per pop.
`default_nettype none

module jmsp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire jmsp_pkg::res_pair_t push,
  input  wire logic                pop,
  output jmsp_pkg::result_t        head,
  output logic                     not_empty,
  output logic                     room_two
);

  jmsp_pkg::result_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill, fill_next;
  logic       do_pop;

  assign not_empty = (fill != 3'd0);
  assign room_two  = (fill <= 3'd2);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];
  assign fill_next = fill + 3'(push.count) - 3'(do_pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jmsp_checker.sv =====
// Port-level checks of the marker segment parser, bound to its top level.
`default_nettype none

`include "jpeg_marker_segment_parser_assert.svh"

module jmsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  kind,
  input wire logic [2:0]  error_code,
  input wire logic [7:0]  marker_code,
  input wire logic [31:0] segment_offset,
  input wire logic [15:0] body_length,
  input wire logic [15:0] value_a,
  input wire logic [15:0] value_b,
  input wire logic [7:0]  value_c,
  input wire logic [7:0]  value_d,
  input wire logic        last
);

  logic [110:0] word;
  logic         held, err_match;
  logic         soi_word, soi_ok, scan_word, scan_ok, comp_word, nib_ok;

  assign word      = {kind, error_code, marker_code, segment_offset, body_length,
                      value_a, value_b, value_c, value_d, last};
  assign held      = out_valid && out_stall;
  assign err_match = (kind == jmsp_pkg::KIND_ERROR) == (error_code != jmsp_pkg::ERR_NONE);
  assign soi_word  = out_valid && (kind == jmsp_pkg::KIND_SOI);
  assign soi_ok    = (marker_code == jmsp_pkg::MARK_SOI) && (segment_offset == 32'd0) &&
                     (body_length == 16'd0);
  assign scan_word = out_valid && (kind == jmsp_pkg::KIND_SCAN);
  assign scan_ok   = (marker_code == jmsp_pkg::MARK_SOS) && (body_length == 16'd0) && last;
  assign comp_word = out_valid && (kind == jmsp_pkg::KIND_COMPONENT);
  assign nib_ok    = (value_b <= {8'd0, jmsp_pkg::NIBBLE_MASK}) &&
                     (value_c <= jmsp_pkg::NIBBLE_MASK);

  // a held word must not move
  `JMSP_ASSERT_NEXT(a_hold, held, out_valid && $stable(word), "output word changed while stalled")

  `JMSP_ASSERT_SAME(a_err_kind, out_valid, err_match, "error code disagrees with kind")

  `JMSP_ASSERT_SAME(a_soi, soi_word, soi_ok, "start of image word malformed")

  `JMSP_ASSERT_SAME(a_scan, scan_word, scan_ok, "scan start word malformed")

  `JMSP_ASSERT_SAME(a_nibble, comp_word, nib_ok, "component nibble out of range")

endmodule

bind jpeg_marker_segment_parser jmsp_checker u_jmsp_checker (.*);

`default_nettype wire

// ===== bench/tb_jpeg_marker_segment_parser.sv =====
// Self-checking testbench for the JPEG marker segment parser: directed rows, then random files.
`timescale 1ns / 100ps

module tb_jpeg_marker_segment_parser;
  import jmsp_pkg::*;

  localparam int PARSED_TARGET = 650;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic [7:0] b;
    bit         fs;
    bit         fe;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        file_start = 1'b0;
  logic        file_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [2:0]  error_code;
  logic [7:0]  marker_code;
  logic [31:0] segment_offset;
  logic [15:0] body_length;
  logic [15:0] value_a;
  logic [15:0] value_b;
  logic [7:0]  value_c;
  logic [7:0]  value_d;
  logic        last;

  // parser shadow state
  phase_t      ph;
  logic [31:0] at_pos;
  logic [31:0] seg_at;
  logic [7:0]  mk_lo;
  logic [7:0]  len_hi;
  logic [15:0] body_len_q;
  logic [15:0] body_cnt;
  logic [15:0] fld_a;
  logic [15:0] fld_b;
  logic [7:0]  fld_c;
  logic [7:0]  n_comp;
  logic [15:0] comp_word;

  result_t     step_out[$];
  result_t     pending_reports[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  file_bytes[$];

  int send_gap_pct = 0;
  int recv_hold_pct = 0;
  int long_hold = 0;
  int cycle_cnt = 0;
  int fail_cnt = 0;
  int parsed_cnt = 0;
  int sent_cnt = 0;
  int file_cnt = 0;
  int checked_cnt = 0;
  int kind_tally[0:7];

  jpeg_marker_segment_parser u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .file_start(file_start),
    .file_end(file_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .error_code(error_code),
    .marker_code(marker_code),
    .segment_offset(segment_offset),
    .body_length(body_length),
    .value_a(value_a),
    .value_b(value_b),
    .value_c(value_c),
    .value_d(value_d),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return $urandom_range(0, 255);
  endfunction

  task automatic restart_parse();
    ph         = PH_SOI1;
    at_pos     = '0;
    seg_at     = '0;
    mk_lo      = '0;
    len_hi     = '0;
    body_len_q = '0;
    body_cnt   = '0;
    fld_a      = '0;
    fld_b      = '0;
    fld_c      = '0;
    n_comp     = '0;
    comp_word  = '0;
  endtask

  task automatic emit_report(input logic [2:0] k, input logic [2:0] e, input logic [7:0] m,
                             input logic [31:0] o, input logic [15:0] l,
                             input logic [15:0] va, input logic [15:0] vb,
                             input logic [7:0] vc, input logic [7:0] vd);
    result_t r;
    r.kind           = k;
    r.error_code     = e;
    r.marker_code    = m;
    r.segment_offset = o;
    r.body_length    = l;
    r.value_a        = va;
    r.value_b        = vb;
    r.value_c        = vc;
    r.value_d        = vd;
    r.last           = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic emit_segment();
    emit_report(KIND_SEGMENT, ERR_NONE, mk_lo, seg_at, body_len_q, fld_a, fld_b, fld_c, n_comp);
  endtask

  // Expected reports for one accepted byte, left in step_out.
  task automatic parse_step(input logic [7:0] b, input bit fs, input bit fe);
    logic [31:0] pos;
    logic [15:0] len16;
    int unsigned idx;
    int unsigned tail;
    int unsigned rec;
    int unsigned at;
    bit          fin;
    bit          sof;
    result_t     r;
    step_out.delete();
    if (fs) restart_parse();
    pos = at_pos;
    if (ph != PH_IDLE && ph != PH_HALT) parsed_cnt++;
    case (ph)
      PH_SOI1: begin
        if (b != MARK_PREFIX || fe) begin
          emit_report(KIND_ERROR, ERR_NO_SOI, 0, 0, 0, 0, 0, 0, 0);
          ph = PH_HALT;
        end else begin
          ph = PH_SOI2;
        end
      end
      PH_SOI2: begin
        if (b != MARK_SOI) begin
          emit_report(KIND_ERROR, ERR_NO_SOI, 0, 0, 0, 0, 0, 0, 0);
          ph = PH_HALT;
        end else begin
          emit_report(KIND_SOI, ERR_NONE, MARK_SOI, 0, 0, 0, 0, 0, 0);
          if (fe) begin
            emit_report(KIND_ERROR, ERR_EARLY_END, 0, pos + 32'd1, 0, 0, 0, 0, 0);
            ph = PH_HALT;
          end else begin
            ph = PH_MK1;
          end
        end
      end
      PH_MK1: begin
        seg_at     = pos;
        mk_lo      = '0;
        len_hi     = '0;
        body_len_q = '0;
        body_cnt   = '0;
        fld_a      = '0;
        fld_b      = '0;
        fld_c      = '0;
        n_comp     = '0;
        comp_word  = '0;
        if (b != MARK_PREFIX) begin
          emit_report(KIND_ERROR, ERR_BAD_MARKER, 0, seg_at, 0, 0, 0, 0, 0);
          ph = PH_HALT;
        end else if (fe) begin
          emit_report(KIND_ERROR, ERR_EARLY_END, 0, seg_at, 0, 0, 0, 0, 0);
          ph = PH_HALT;
        end else begin
          ph = PH_MK2;
        end
      end
      PH_MK2, PH_LEN1: begin
        if (ph == PH_MK2) mk_lo = b;
        else len_hi = b;
        if (fe) begin
          emit_report(KIND_ERROR, ERR_EARLY_END, mk_lo, seg_at, 0, 0, 0, 0, 0);
          ph = PH_HALT;
        end else begin
          ph = (ph == PH_MK2) ? PH_LEN1 : PH_LEN2;
        end
      end
      PH_LEN2: begin
        len16 = {len_hi, b};
        if (len16 <= LEN_MIN) begin
          emit_report(KIND_ERROR, ERR_BAD_MARKER, mk_lo, seg_at, 0, 0, 0, 0, 0);
          ph = PH_HALT;
        end else begin
          body_len_q = len16 - 16'd2;
          body_cnt   = '0;
          if (fe) begin
            emit_report(KIND_ERROR, ERR_BODY_SHORT, mk_lo, seg_at, body_len_q, 0, 0, 0, 0);
            ph = PH_HALT;
          end else begin
            ph = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        idx      = body_cnt;
        sof      = (mk_lo == MARK_SOF0 || mk_lo == MARK_SOF2);
        body_cnt = body_cnt + 16'd1;
        fin      = (body_cnt >= body_len_q);
        if (sof) begin
          if (idx == 0) begin
            fld_c = b;
          end else if (idx <= 2) begin
            fld_a = {fld_a[7:0], b};
          end else if (idx <= 4) begin
            fld_b = {fld_b[7:0], b};
          end else if (idx == 5) begin
            n_comp = b;
          end else begin
            rec = (idx - 6) / 3;
            at  = (idx - 6) % 3;
            if (rec < n_comp) begin
              if (at == 0) begin
                comp_word = {b, 8'h00};
              end else if (at == 1) begin
                comp_word = comp_word | {8'h00, b};
              end else begin
                emit_report(KIND_COMPONENT, ERR_NONE, mk_lo, seg_at, body_len_q,
                            {8'h00, comp_word[15:8]}, {12'h000, comp_word[7:4]},
                            {4'h0, comp_word[3:0]}, b);
              end
            end
          end
          // SOF reports its segment at the sixth body byte or at a shorter end
          if (idx == 5 || (fin && idx < 5)) emit_segment();
        end else if (mk_lo == MARK_DRI) begin
          if (idx <= 1) fld_a = {fld_a[7:0], b};
        end else if (mk_lo == MARK_SOS) begin
          tail = 1 + 2 * int'(n_comp);
          if (idx == 0) begin
            n_comp = b;
          end else if (idx < tail) begin
            if (idx % 2 == 1) begin
              comp_word = {8'h00, b};
            end else begin
              emit_report(KIND_COMPONENT, ERR_NONE, mk_lo, seg_at, body_len_q, comp_word,
                          {12'h000, b[7:4]}, {4'h0, b[3:0]}, 0);
            end
          end else if (idx == tail) begin
            fld_a = {8'h00, b};
          end else if (idx == tail + 1) begin
            fld_b = {8'h00, b};
          end else if (idx == tail + 2) begin
            fld_c = b;
          end
        end
        if (fin) begin
          if (!sof) emit_segment();
          if (mk_lo == MARK_SOS) begin
            ph = PH_SCAN;
          end else if (fe) begin
            emit_report(KIND_ERROR, ERR_EARLY_END, 0, pos + 32'd1, 0, 0, 0, 0, 0);
            ph = PH_HALT;
          end else begin
            ph = PH_MK1;
          end
        end else if (fe) begin
          emit_report(KIND_ERROR, ERR_BODY_SHORT, mk_lo, seg_at, body_len_q, 0, 0, 0, 0);
          ph = PH_HALT;
        end
      end
      PH_SCAN: begin
        emit_report(KIND_SCAN, ERR_NONE, MARK_SOS, pos, 0, 0, 0, 0, 0);
        ph = PH_IDLE;
      end
      default: ;
    endcase
    at_pos = pos + 32'd1;
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
    end
  endtask

  // Offer one word, wait for it to be taken, then queue what it should raise.
  task automatic send_word(input logic [7:0] b, input bit fs, input bit fe,
                           input bit typed, input result_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    file_start <= fs;
    file_end   <= fe;
    // stall is settled mid-cycle, so the decision is free of edge races
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    sent_cnt++;
    parse_step(b, fs, fe);
    if (typed) pending_reports.push_back(want);
    else foreach (step_out[i]) pending_reports.push_back(step_out[i]);
  endtask

  task automatic add_row(input logic [7:0] b, input bit fs, input bit fe, input bit typed,
                         input logic [2:0] k, input logic [2:0] e, input logic [7:0] m,
                         input logic [31:0] o);
    dir_row_t row;
    row.b     = b;
    row.fs    = fs;
    row.fe    = fe;
    row.typed = typed;
    row.want  = '0;
    row.want.kind           = k;
    row.want.error_code     = e;
    row.want.marker_code    = m;
    row.want.segment_offset = o;
    row.want.last           = 1'b1;
    dir_rows.push_back(row);
  endtask

  // One random file into file_bytes: mostly well formed, some broken.
  task automatic build_file();
    int          nseg;
    int          s;
    int          i;
    int          n;
    int          pick;
    int          cut;
    bit          stop;
    logic [7:0]  code;
    logic [15:0] seglen;
    logic [7:0]  body[$];
    file_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) file_bytes.push_back(rand_byte());
    end else begin
      file_bytes.push_back(MARK_PREFIX);
      file_bytes.push_back(MARK_SOI);
      nseg = $urandom_range(1, 4);
      stop = 1'b0;
      for (s = 0; s < nseg && !stop; s++) begin
        body.delete();
        pick = $urandom_range(0, 19);
        if (pick <= 4) begin
          code = (pick <= 2) ? MARK_SOF0 : MARK_SOF2;
          n = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 4);
          for (i = 0; i < 5; i++) body.push_back(rand_byte());
          body.push_back(n[7:0]);
          for (i = 0; i < 3 * ((n > 4) ? 4 : n); i++) body.push_back(rand_byte());
        end else if (pick <= 6) begin
          code = MARK_DRI;
          for (i = 0; i < 2; i++) body.push_back(rand_byte());
        end else if (pick <= 9) begin
          code = MARK_SOS;
          n = $urandom_range(0, 4);
          body.push_back(n[7:0]);
          for (i = 0; i < 2 * n + 3; i++) body.push_back(rand_byte());
        end else begin
          code = rand_byte();
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) body.push_back(rand_byte());
        end
        // length that disagrees with the fields
        if (pick <= 9 && $urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) == 1) begin
            cut = $urandom_range(1, body.size());
            while (body.size() > cut) void'(body.pop_back());
          end else begin
            repeat ($urandom_range(1, 3)) body.push_back(rand_byte());
          end
        end
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back(code);
        if (pick == 10) begin
          file_bytes.push_back(8'h00);
          file_bytes.push_back($urandom_range(0, 2));
          stop = 1'b1;
        end else if (pick == 11) begin
          // maximum length, cut off after a few body bytes
          file_bytes.push_back(8'hFF);
          file_bytes.push_back(8'hFF);
          repeat ($urandom_range(1, 4)) file_bytes.push_back(rand_byte());
          stop = 1'b1;
        end else begin
          seglen = body.size() + 2;
          file_bytes.push_back(seglen[15:8]);
          file_bytes.push_back(seglen[7:0]);
          foreach (body[j]) file_bytes.push_back(body[j]);
          if (code == MARK_SOS) begin
            repeat ($urandom_range(1, 3)) file_bytes.push_back(rand_byte());
            stop = 1'b1;
          end
        end
      end
      if ($urandom_range(0, 9) == 0)
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = rand_byte();
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
    end
  endtask

  task automatic show_report(input string tag, input result_t r);
    $display("  %s kind=%0d err=%0d marker=%02h offset=%0d len=%0d a=%04h b=%04h c=%02h d=%02h last=%0d",
             tag, r.kind, r.error_code, r.marker_code, r.segment_offset, r.body_length,
             r.value_a, r.value_b, r.value_c, r.value_d, r.last);
  endtask

  // receiver: random stall, or a long counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_hold_pct);
      end
    end
  end

  always @(negedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {kind, error_code, marker_code, segment_offset, body_length,
             value_a, value_b, value_c, value_d, last};
      kind_tally[got.kind]++;
      if (pending_reports.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
          $display("Unexpected result word at cycle %0d", cycle_cnt);
          show_report("actual  ", got);
        end
      end else begin
        want = pending_reports.pop_front();
        checked_cnt++;
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("Mismatch at cycle %0d", cycle_cnt);
            show_report("expected", want);
            show_report("actual  ", got);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_cnt, pending_reports.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit end_flag;
    bit pressed;
    int stage;
    foreach (kind_tally[k]) kind_tally[k] = 0;
    restart_parse();

    // parse starts without any file_start after reset
    add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 1, KIND_ERROR, ERR_NO_SOI, 8'h00, 0);
    // file that ends on its first byte; first byte not FF
    add_row(8'hFF, 1, 1, 1, KIND_ERROR, ERR_NO_SOI, 8'h00, 0);
    add_row(8'h00, 1, 0, 1, KIND_ERROR, ERR_NO_SOI, 8'h00, 0);
    // SOI and end of file together
    add_row(8'hFF, 1, 0, 0, 0, 0, 0, 0);
    add_row(8'hD8, 0, 1, 0, 0, 0, 0, 0);
    // header byte that should be FF
    add_row(8'hFF, 1, 0, 0, 0, 0, 0, 0);
    add_row(8'hD8, 0, 0, 1, KIND_SOI, ERR_NONE, MARK_SOI, 0);
    add_row(8'h7F, 0, 0, 1, KIND_ERROR, ERR_BAD_MARKER, 8'h00, 2);
    // SOF0 with a one-byte body, SOS with no components, then the scan
    add_row(8'hFF, 1, 0, 0, 0, 0, 0, 0);
    add_row(8'hD8, 0, 0, 1, KIND_SOI, ERR_NONE, MARK_SOI, 0);
    add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'hC0, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h03, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'hDA, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h03, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 1, 1, KIND_SCAN, ERR_NONE, MARK_SOS, 12);
    // length field of two
    add_row(8'hFF, 1, 0, 0, 0, 0, 0, 0);
    add_row(8'hD8, 0, 0, 1, KIND_SOI, ERR_NONE, MARK_SOI, 0);
    add_row(8'hFF, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h12, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 0, 0, 0, 0);
    add_row(8'h02, 0, 0, 1, KIND_ERROR, ERR_BAD_MARKER, 8'h12, 2);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct  = 20;
    recv_hold_pct = 48;
    foreach (dir_rows[i])
      send_word(dir_rows[i].b, dir_rows[i].fs, dir_rows[i].fe, dir_rows[i].typed,
                dir_rows[i].want);
    parsed_cnt = 0;

    pressed = 1'b0;
    while (parsed_cnt < PARSED_TARGET) begin
      stage = parsed_cnt * 3 / PARSED_TARGET;
      if (stage == 0) begin
        send_gap_pct  = 20;
        recv_hold_pct = 48;
      end else if (stage == 1) begin
        send_gap_pct  = 48;
        recv_hold_pct = 20;
      end else begin
        send_gap_pct  = 0;
        recv_hold_pct = 0;
        // long hold-off while bytes keep coming, so the output queue fills up
        if (!pressed) begin
          long_hold = 300;
          pressed   = 1'b1;
        end
      end
      build_file();
      file_cnt++;
      end_flag = ($urandom_range(0, 3) != 0);
      foreach (file_bytes[i])
        send_word(file_bytes[i], i == 0, end_flag && (i == file_bytes.size() - 1), 0, '0);
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Summary: %0d bytes in %0d random files plus directed rows, %0d results checked",
             sent_cnt, file_cnt, checked_cnt);
    $display("Summary: SOI %0d, segments %0d, component records %0d, scan starts %0d, errors %0d",
             kind_tally[KIND_SOI], kind_tally[KIND_SEGMENT], kind_tally[KIND_COMPONENT],
             kind_tally[KIND_SCAN], kind_tally[KIND_ERROR]);
    if (fail_cnt == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
